// ===== hw/rtl/mic_pkg.sv =====
// shared types, constants and command codes for the map inversion builder
`timescale 1ns / 1ps

package mic_pkg;

  // sizing
  localparam int MaxSources = 1024;
  localparam int MaxTargets = 256;
  localparam int SrcAw      = $clog2(MaxSources);       // source / member address
  localparam int TgtW       = $clog2(MaxTargets);       // target index
  localparam int CntW       = $clog2(MaxSources + 1);   // counts, offsets, source count
  localparam int OfsAw      = $clog2(MaxTargets + 1);   // offset table address
  localparam int NtW        = 9;                        // num_targets register
  localparam int FuncW      = 3;
  localparam int IdxW       = 11;
  localparam int StatW      = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_APPEND = 3'd1,
    FUNC_BUILD  = 3'd2,
    FUNC_RD_OFS = 3'd3,
    FUNC_RD_MBR = 3'd4
  } func_t;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_TARGET    = 3'd1,
    ST_FULL      = 3'd2,
    ST_INDEX     = 3'd3,
    ST_NOT_BUILT = 3'd4
  } status_t;

  // which result gets loaded into the output register
  typedef enum logic [1:0] {
    RES_IMM,
    RES_READ,
    RES_BUILD
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHK_A,
    S_CHK_B,
    S_CLR,
    S_CNT_A,
    S_CNT_B,
    S_CNT_C,
    S_PFX_A,
    S_PFX_B,
    S_PFX_END,
    S_PLC_A,
    S_PLC_B,
    S_PLC_C,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic     accept;       // request taken this cycle
    logic     idx_clr;      // walk counter and running sum to zero
    logic     idx_inc;      // advance walk counter
    logic     chk;          // stored target under test
    logic     cnt_zero_wr;  // count[idx] <= 0 (clear sweep)
    logic     cnt_bump_wr;  // count[target] <= count + 1
    logic     pfx_rd;       // count read addressed by walk counter
    logic     pfx_wr;       // offset[idx] <= run, run += count, count[idx] <= 0
    logic     pfx_end;      // offset[idx] <= run (closing offset)
    logic     plc_wr;       // member[offset + count] <= source
    logic     out_load;     // load output register
    res_sel_t res_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_src;   // walk counter at last stored source
    logic last_tgt;   // walk counter at last active target
    logic src_zero;   // no sources stored
    logic chk_bad;    // stored target out of range
  } dp_sts_t;

endpackage

// ===== hw/rtl/mic_datapath.sv =====
// datapath of the map inversion builder: tables, walk counter, result register
`timescale 1ns / 1ps

module mic_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mic_pkg::dp_cmd_t          cmd,
  output mic_pkg::dp_sts_t          sts,
  input  logic [mic_pkg::FuncW-1:0] in_func,
  input  logic [mic_pkg::TgtW-1:0]  in_target,
  input  logic [mic_pkg::IdxW-1:0]  in_index,
  input  logic                      cfg_we,
  input  logic [mic_pkg::NtW-1:0]   cfg_data,
  output logic [mic_pkg::CntW-1:0]  out_value,
  output logic [mic_pkg::StatW-1:0] out_status
);
  import mic_pkg::*;

  // tables
  logic [TgtW-1:0]  src_tgt_mem [MaxSources];
  logic [CntW-1:0]  cnt_mem     [MaxTargets];
  logic [CntW-1:0]  ofs_mem     [MaxTargets+1];
  logic [SrcAw-1:0] mbr_mem     [MaxSources];

  // control state
  logic [CntW-1:0]  src_cnt_r;
  logic             built_r;
  logic [NtW-1:0]   nt_r;
  logic [CntW-1:0]  idx_r;
  logic [CntW-1:0]  run_r;
  logic             chk_bad_r;

  // read data and captured request
  logic [TgtW-1:0]  tgt_q_r;
  logic [CntW-1:0]  cnt_q_r;
  logic [CntW-1:0]  ofs_q_r;
  logic [SrcAw-1:0] mbr_q_r;
  logic [FuncW-1:0] req_func_r;
  logic [IdxW-1:0]  req_index_r;
  logic [CntW-1:0]  out_value_r;
  status_t          out_status_r;

  logic [NtW-1:0]   nb;
  logic [CntW-1:0]  idx_inc;
  logic [TgtW-1:0]  cnt_raddr;
  logic [TgtW-1:0]  cnt_waddr;
  logic [CntW-1:0]  cnt_wdata;
  logic             cnt_we;
  logic [OfsAw-1:0] ofs_raddr;
  logic [CntW-1:0]  plc_pos;
  logic             imm_load;
  logic             append_ok;
  logic [CntW-1:0]  imm_value;
  status_t          imm_status;
  logic [CntW-1:0]  rd_value;
  status_t          rd_status;
  logic [CntW-1:0]  res_value;
  status_t          res_status;

  // active bucket count: zero acts as one, clamp at the table size
  always_comb begin
    if (nt_r == '0) begin
      nb = NtW'(1);
    end else if (nt_r > NtW'(MaxTargets)) begin
      nb = NtW'(MaxTargets);
    end else begin
      nb = nt_r;
    end
  end

  assign idx_inc      = idx_r + 1'b1;
  assign sts.last_src = (idx_inc == src_cnt_r);
  assign sts.last_tgt = (idx_inc == CntW'(nb));
  assign sts.src_zero = (src_cnt_r == '0);
  assign sts.chk_bad  = (NtW'(tgt_q_r) >= nb);

  assign cnt_raddr = cmd.pfx_rd ? idx_r[TgtW-1:0] : tgt_q_r;
  assign cnt_we    = cmd.cnt_zero_wr | cmd.pfx_wr | cmd.cnt_bump_wr;
  assign cnt_waddr = (cmd.cnt_zero_wr | cmd.pfx_wr) ? idx_r[TgtW-1:0] : tgt_q_r;
  assign cnt_wdata = (cmd.cnt_zero_wr | cmd.pfx_wr) ? '0 : cnt_q_r + 1'b1;
  assign ofs_raddr = cmd.accept ? in_index[OfsAw-1:0] : OfsAw'(tgt_q_r);
  assign plc_pos   = ofs_q_r + cnt_q_r;
  assign imm_load  = cmd.out_load && (cmd.res_sel == RES_IMM);

  // clear, append and unused codes finish in the accept cycle
  always_comb begin
    imm_value  = src_cnt_r;
    imm_status = ST_OK;
    append_ok  = 1'b0;
    case (in_func)
      FUNC_CLEAR: imm_value = '0;
      FUNC_APPEND: begin
        if (NtW'(in_target) >= nb) begin
          imm_status = ST_TARGET;
        end else if (src_cnt_r == CntW'(MaxSources)) begin
          imm_status = ST_FULL;
        end else begin
          append_ok = 1'b1;
          imm_value = src_cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_value  = '0;
    rd_status = ST_OK;
    if (!built_r) begin
      rd_status = ST_NOT_BUILT;
    end else if (req_func_r == FUNC_RD_OFS) begin
      if (req_index_r > IdxW'(nb)) begin
        rd_status = ST_INDEX;
      end else begin
        rd_value = ofs_q_r;
      end
    end else if (req_index_r >= src_cnt_r) begin
      rd_status = ST_INDEX;
    end else begin
      rd_value = CntW'(mbr_q_r);
    end
  end

  always_comb begin
    case (cmd.res_sel)
      RES_READ: begin
        res_value  = rd_value;
        res_status = rd_status;
      end
      RES_BUILD: begin
        res_value  = src_cnt_r;
        res_status = chk_bad_r ? ST_TARGET : ST_OK;
      end
      default: begin
        res_value  = imm_value;
        res_status = imm_status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= '0;
      built_r   <= 1'b0;
      nt_r      <= NtW'(MaxTargets);
      idx_r     <= '0;
      run_r     <= '0;
      chk_bad_r <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_inc;
      end
      if (cmd.idx_clr) begin
        run_r <= '0;
      end else if (cmd.pfx_wr) begin
        run_r <= run_r + cnt_q_r;
      end
      if (cmd.accept) begin
        chk_bad_r <= 1'b0;
      end else if (cmd.chk && sts.chk_bad) begin
        chk_bad_r <= 1'b1;
      end
      if (imm_load && (in_func == FUNC_CLEAR)) begin
        src_cnt_r <= '0;
        built_r   <= 1'b0;
      end
      if (imm_load && append_ok) begin
        src_cnt_r <= src_cnt_r + 1'b1;
        built_r   <= 1'b0;
      end
      if (cmd.out_load && (cmd.res_sel == RES_BUILD) && !chk_bad_r) begin
        built_r <= 1'b1;
      end
      if (cfg_we) begin
        nt_r    <= cfg_data;
        built_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_q_r <= src_tgt_mem[idx_r[SrcAw-1:0]];
    if (imm_load && append_ok) begin
      src_tgt_mem[src_cnt_r[SrcAw-1:0]] <= in_target;
    end
  end

  always_ff @(posedge clk) begin
    cnt_q_r <= cnt_mem[cnt_raddr];
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ofs_q_r <= ofs_mem[ofs_raddr];
    if (cmd.pfx_wr || cmd.pfx_end) begin
      ofs_mem[idx_r[OfsAw-1:0]] <= run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mbr_q_r <= mbr_mem[in_index[SrcAw-1:0]];
    end
    if (cmd.plc_wr) begin
      mbr_mem[plc_pos[SrcAw-1:0]] <= idx_r[SrcAw-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_func_r  <= in_func;
      req_index_r <= in_index;
    end
    if (cmd.out_load) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ===== hw/rtl/mic_ctrl.sv =====
// sequencer of the map inversion builder: handshakes and build phases
`timescale 1ns / 1ps

module mic_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [mic_pkg::FuncW-1:0] in_func,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  mic_pkg::dp_sts_t          sts,
  output mic_pkg::dp_cmd_t          cmd
);
  import mic_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = RES_IMM;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          cmd.accept = 1'b1;
          case (in_func)
            FUNC_BUILD: begin
              cmd.idx_clr = 1'b1;
              state_nxt   = sts.src_zero ? S_CLR : S_CHK_A;
            end
            FUNC_RD_OFS, FUNC_RD_MBR: state_nxt = S_READ;
            default: begin
              cmd.out_load = 1'b1;
              cmd.res_sel  = RES_IMM;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.res_sel = RES_READ;
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CHK_A: state_nxt = S_CHK_B;
      S_CHK_B: begin
        cmd.chk = 1'b1;
        if (sts.chk_bad) begin
          state_nxt = S_DONE;
        end else if (sts.last_src) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CHK_A;
        end
      end
      S_CLR: begin
        cmd.cnt_zero_wr = 1'b1;
        if (sts.last_tgt) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = sts.src_zero ? S_PFX_A : S_CNT_A;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CNT_A: state_nxt = S_CNT_B;
      S_CNT_B: state_nxt = S_CNT_C;
      S_CNT_C: begin
        cmd.cnt_bump_wr = 1'b1;
        if (sts.last_src) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PFX_A;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CNT_A;
        end
      end
      S_PFX_A: begin
        cmd.pfx_rd = 1'b1;
        state_nxt  = S_PFX_B;
      end
      S_PFX_B: begin
        cmd.pfx_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = sts.last_tgt ? S_PFX_END : S_PFX_A;
      end
      S_PFX_END: begin
        cmd.pfx_end = 1'b1;
        cmd.idx_clr = 1'b1;
        state_nxt   = sts.src_zero ? S_DONE : S_PLC_A;
      end
      S_PLC_A: state_nxt = S_PLC_B;
      S_PLC_B: state_nxt = S_PLC_C;
      S_PLC_C: begin
        cmd.plc_wr      = 1'b1;
        cmd.cnt_bump_wr = 1'b1;
        if (sts.last_src) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_PLC_A;
        end
      end
      S_DONE: begin
        cmd.res_sel = RES_BUILD;
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  // offset read data is not held while the state waits, so a read must never wait for the output
  a_read_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> slot_free)
    else $error("read result found output register busy");

  a_read_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == FUNC_RD_OFS || in_func == FUNC_RD_MBR))
      |=> (state_r == S_READ))
    else $error("read request did not enter read state");

  a_build_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == FUNC_BUILD))
      |=> (state_r == S_CHK_A || state_r == S_CLR))
    else $error("build request did not start a walk");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("request taken while busy");

endmodule

// ===== hw/rtl/map_inversion_csr_builder.sv =====
// top level of the map inversion builder (many-to-one map into compressed buckets)
`timescale 1ns / 1ps

// usage
//   input channel (in_valid / in_ready) carries one request: in_func selects clear,
//   append source, build, read offset or read member; in_target and in_index are
//   its operands. every request gives exactly one result on the output channel
//   (out_valid / out_ready) as out_value and out_status.
//   cfg channel writes num_targets; always ready, write only while idle. a write
//   drops the built state.
//   clear, append and unused codes give their result in the cycle after the
//   request is taken and can be taken every cycle while the receiver keeps
//   taking results. offset and member reads go through one registered table
//   read, then the result register. build walks the tables in place: a range
//   check over the sources, a clear of the bucket counts, a count pass over the
//   sources, a prefix sum over the buckets plus the closing offset, a place pass
//   over the sources, then the result; a stale target stops it in the check.
//   no request is taken during build.
//   reset clears the source count, the built state and sets num_targets to 256;
//   table contents are not cleared and need no clearing pass.
//   when the receiver stalls, the result waits in the output register and the
//   next request is held off until that register frees.

module map_inversion_csr_builder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mic_pkg::FuncW-1:0] in_func,
  input  logic [mic_pkg::TgtW-1:0]  in_target,
  input  logic [mic_pkg::IdxW-1:0]  in_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mic_pkg::CntW-1:0]  out_value,
  output logic [mic_pkg::StatW-1:0] out_status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mic_pkg::NtW-1:0]   cfg_data
);
  import mic_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config register always takes the write
  assign cfg_ready = 1'b1;

  // sequencer: request handshake, build phase walk, output valid
  mic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables, counters and the result register
  mic_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_func),
    .in_target  (in_target),
    .in_index   (in_index),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

// ===== tb/map_inversion_csr_builder_test.sv =====
// self-checking testbench for the map inversion builder
`timescale 1ns / 1ps

module map_inversion_csr_builder_test;
  import mic_pkg::*;

  // a full build (1024 sources) gives no handshake at all until its result
  localparam int StallLimit     = 40000;
  localparam int RequestGoal    = 1700;
  localparam int LongHoldCycles = 400;

  // codes the block leaves unused: they only report the source count
  localparam logic [FuncW-1:0] FUNC_SPARE5 = 3'd5;
  localparam logic [FuncW-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FuncW-1:0] FUNC_SPARE7 = 3'd7;

  typedef struct packed {
    logic [CntW-1:0] value;
    status_t         status;
  } result_t;

  // one line of the directed script: a request or a num_targets write
  typedef struct {
    bit               cfg;
    logic [NtW-1:0]   nt;
    logic [FuncW-1:0] func;
    logic [TgtW-1:0]  tgt;
    logic [IdxW-1:0]  idx;
    bit               typed;   // expectation written in the script
    logic [CntW-1:0]  value;
    status_t          status;
  } row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_TRICKLE} rx_mode_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic [FuncW-1:0] in_func    = '0;
  logic [TgtW-1:0]  in_target  = '0;
  logic [IdxW-1:0]  in_index   = '0;
  logic             out_ready  = 1'b0;
  logic             cfg_valid  = 1'b0;
  logic [NtW-1:0]   cfg_data   = '0;
  logic             in_ready;
  logic             out_valid;
  logic [CntW-1:0]  out_value;
  logic [StatW-1:0] out_status;
  logic             cfg_ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  map_inversion_csr_builder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_target  (in_target),
    .in_index   (in_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor: its own copy of the map, the offset table and the members
  // ---------------------------------------------------------------------------
  logic [TgtW-1:0]  map_target    [MaxSources];
  logic [CntW-1:0]  bucket_start  [MaxTargets+1];
  logic [SrcAw-1:0] bucket_source [MaxSources];
  int unsigned      mapped_sources  = 0;
  bit               buckets_valid   = 1'b0;
  logic [NtW-1:0]   num_targets_reg = NtW'(MaxTargets);

  result_t     pending_results [$];   // results still owed by the block
  int unsigned mismatches     = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen   = 0;
  int unsigned cfg_writes     = 0;
  int unsigned status_tally [5] = '{default: 0};

  // out of range register values fold to one bucket or to the table size
  function automatic int unsigned active_buckets();
    if (num_targets_reg == 0) return 1;
    if (num_targets_reg > MaxTargets) return MaxTargets;
    return num_targets_reg;
  endfunction

  // check targets, count, prefix sum, then place in ascending source order
  function automatic status_t rebuild_buckets();
    int unsigned nb, run, t, s, b;
    int unsigned tally [MaxTargets];
    nb = active_buckets();
    for (s = 0; s < mapped_sources; s++)
      if (map_target[s] >= nb) return ST_TARGET;   // stale target, nothing changes
    for (b = 0; b < MaxTargets; b++) tally[b] = 0;
    for (s = 0; s < mapped_sources; s++) tally[map_target[s]]++;
    run = 0;
    for (b = 0; b < nb; b++) begin
      bucket_start[b] = CntW'(run);
      run += tally[b];
      tally[b] = 0;
    end
    bucket_start[nb] = CntW'(run);
    for (s = 0; s < mapped_sources; s++) begin
      t = map_target[s];
      bucket_source[bucket_start[t] + tally[t]] = SrcAw'(s);
      tally[t]++;
    end
    buckets_valid = 1'b1;
    return ST_OK;
  endfunction

  function automatic result_t invert_step(logic [FuncW-1:0] f, logic [TgtW-1:0] t,
                                          logic [IdxW-1:0] i);
    result_t r;
    r.value  = '0;
    r.status = ST_OK;
    case (f)
      FUNC_CLEAR: begin
        mapped_sources = 0;
        buckets_valid  = 1'b0;
      end
      FUNC_APPEND: begin
        // the target check comes before the full check
        if (t >= active_buckets()) r.status = ST_TARGET;
        else if (mapped_sources >= MaxSources) r.status = ST_FULL;
        else begin
          map_target[mapped_sources] = t;
          mapped_sources++;
          buckets_valid = 1'b0;
        end
        r.value = CntW'(mapped_sources);
      end
      FUNC_BUILD: begin
        r.status = rebuild_buckets();
        r.value  = CntW'(mapped_sources);
      end
      FUNC_RD_OFS: begin
        if (!buckets_valid) r.status = ST_NOT_BUILT;
        else if (i > active_buckets()) r.status = ST_INDEX;
        else r.value = bucket_start[i];
      end
      FUNC_RD_MBR: begin
        if (!buckets_valid) r.status = ST_NOT_BUILT;
        else if (i >= mapped_sources) r.status = ST_INDEX;
        else r.value = CntW'(bucket_source[i]);
      end
      default: r.value = CntW'(mapped_sources);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: results are checked before the request of the same edge is
  // predicted, so the order of the two never matters
  // ---------------------------------------------------------------------------
  logic            row_typed  = 1'b0;
  logic [CntW-1:0] row_value  = '0;
  status_t         row_status = ST_OK;

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with nothing owed: value %0d status %0d", out_value, out_status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_value);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        // the predictor always runs so its state follows the block
        want = invert_step(in_func, in_target, in_index);
        if (row_typed) begin
          want.value  = row_value;
          want.status = row_status;
        end
        status_tally[want.status]++;
        pending_results.push_back(want);
        requests_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        num_targets_reg = cfg_data;
        buckets_valid   = 1'b0;   // any register write drops the built state
        cfg_writes++;
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d results owed",
               quiet_cycles, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: changes mode at random intervals; a hold request from the
  // sender side forces a long stretch of back pressure
  // ---------------------------------------------------------------------------
  int          hold_requests = 0;
  int          holds_served  = 0;
  int unsigned long_left     = 0;
  int unsigned mode_left     = 0;
  int unsigned pattern_ctr   = 0;
  rx_mode_t    ready_mode    = RX_OPEN;

  always @(negedge clk) begin
    pattern_ctr <= pattern_ctr + 1;
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      long_left    <= LongHoldCycles;
      out_ready    <= 1'b0;
    end else if (long_left != 0) begin
      long_left <= long_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(32, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
        RX_COMB:    out_ready <= (pattern_ctr % 5 < 2);
        default:    out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  row_t        script [$];
  int unsigned burst_left = 0;

  function automatic row_t req(logic [FuncW-1:0] f, int unsigned t, int unsigned i,
                               bit typed = 1'b0, int unsigned v = 0,
                               status_t st = ST_OK);
    row_t r;
    r.cfg    = 1'b0;
    r.nt     = '0;
    r.func   = f;
    r.tgt    = TgtW'(t);
    r.idx    = IdxW'(i);
    r.typed  = typed;
    r.value  = CntW'(v);
    r.status = st;
    return r;
  endfunction

  function automatic row_t nt_write(int unsigned n);
    row_t r;
    r     = req(FUNC_CLEAR, 0, 0);
    r.cfg = 1'b1;
    r.nt  = NtW'(n);
    return r;
  endfunction

  // called and left at a falling edge; valid drops only when a gap follows
  task automatic issue(row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_func    <= r.func;
    in_target  <= r.tgt;
    in_index   <= r.idx;
    row_typed  <= r.typed;
    row_value  <= r.value;
    row_status <= r.status;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender pauses until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_num_targets(int unsigned n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= NtW'(n);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_noise();
    issue(req(FuncW'($urandom_range(0, 7)), $urandom_range(0, 255),
              $urandom_range(0, 2047)));
  endtask

  // clear (always if clean), append a map, build it, read offsets and members back;
  // a clean phase keeps its loop appends in range so the map can reach full
  task automatic bucket_phase(int unsigned sources, bit clean);
    int unsigned nb, reads, k, span;
    nb = active_buckets();
    if (clean || $urandom_range(0, 7) != 0) issue(req(FUNC_CLEAR, $urandom, $urandom));
    for (k = 0; k < sources; k++) begin
      if (!clean && $urandom_range(0, 15) == 0)
        send_noise();
      else if (!clean && $urandom_range(0, 11) == 0)
        issue(req(FUNC_APPEND, $urandom_range(0, 255), $urandom));
      else
        issue(req(FUNC_APPEND, $urandom_range(0, nb - 1), $urandom));
    end
    if (clean) issue(req(FUNC_APPEND, MaxTargets - 1, 0));   // full, or a bad target
    // narrowing the register after appending leaves stale targets behind
    if (!clean && $urandom_range(0, 5) == 0) begin
      write_num_targets($urandom_range(1, nb));
      nb = active_buckets();
    end
    issue(req(FUNC_BUILD, $urandom, $urandom));
    span  = (mapped_sources < 40) ? mapped_sources : 40;
    reads = $urandom_range(4, 16) + span;
    for (k = 0; k < reads; k++) begin
      case ($urandom_range(0, 9))
        0: send_noise();
        1, 2, 3, 4:
          issue(req(FUNC_RD_OFS, $urandom, ($urandom_range(0, 7) == 0) ?
                    $urandom_range(0, 2047) : $urandom_range(0, nb)));
        default:
          issue(req(FUNC_RD_MBR, $urandom, ($urandom_range(0, 7) == 0) ?
                    $urandom_range(0, 2047) : $urandom_range(0, mapped_sources)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase, nt, sources;

    // after reset: 256 buckets, nothing stored, nothing built
    script = '{
      req(FUNC_RD_OFS, 0, 0, 1, 0, ST_NOT_BUILT),
      req(FUNC_RD_MBR, 0, 0, 1, 0, ST_NOT_BUILT),
      req(FUNC_BUILD, 0, 0, 1, 0, ST_OK),                 // empty map builds
      req(FUNC_RD_OFS, 0, MaxTargets, 1, 0, ST_OK),       // closing offset
      req(FUNC_RD_OFS, 0, MaxTargets + 1, 1, 0, ST_INDEX),
      req(FUNC_RD_MBR, 0, 0, 1, 0, ST_INDEX),             // no members at all
      req(FUNC_APPEND, 255, 2047, 1, 1, ST_OK),
      req(FUNC_APPEND, 0, 0, 1, 2, ST_OK),
      req(FUNC_APPEND, 255, 0, 1, 3, ST_OK),
      req(FUNC_APPEND, 7, 0, 1, 4, ST_OK),
      req(FUNC_SPARE5, 255, 2047, 1, 4, ST_OK),
      req(FUNC_SPARE6, 128, 1024, 1, 4, ST_OK),
      req(FUNC_SPARE7, 0, 0, 1, 4, ST_OK),
      req(FUNC_RD_OFS, 0, 0, 1, 0, ST_NOT_BUILT),         // append dropped the build
      req(FUNC_BUILD, 0, 0, 1, 4, ST_OK),
      req(FUNC_RD_OFS, 0, 8),
      req(FUNC_RD_MBR, 0, 2),                             // first member of bucket 255
      req(FUNC_RD_MBR, 0, 2047, 1, 0, ST_INDEX),
      req(FUNC_RD_OFS, 0, 2047, 1, 0, ST_INDEX),
      nt_write(100),
      req(FUNC_RD_OFS, 0, 0, 1, 0, ST_NOT_BUILT),         // register write dropped it
      req(FUNC_BUILD, 0, 0, 1, 4, ST_TARGET),             // stored 255 now stale
      req(FUNC_APPEND, 100, 0, 1, 4, ST_TARGET),
      req(FUNC_CLEAR, 255, 2047, 1, 0, ST_OK),
      nt_write(0),                                        // folds to one bucket
      req(FUNC_APPEND, 1, 0, 1, 0, ST_TARGET),
      req(FUNC_APPEND, 0, 0, 1, 1, ST_OK),
      req(FUNC_BUILD, 0, 0),
      req(FUNC_RD_OFS, 0, 1),
      req(FUNC_RD_OFS, 0, 2, 1, 0, ST_INDEX),
      nt_write(511)                                       // folds to 256
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[n]) begin
      if (script[n].cfg) write_num_targets(script[n].nt);
      else issue(script[n]);
    end

    // random phases: register extremes and 200 first, then random settings
    phase = 0;
    while (requests_taken < RequestGoal) begin
      case (phase)
        0: nt = 1;
        1: nt = MaxTargets;
        2: nt = 200;
        3: nt = 0;
        4: nt = (1 << NtW) - 1;
        default: begin
          case ($urandom_range(0, 5))
            0: nt = 1;
            1: nt = 2;
            2: nt = MaxTargets;
            3: nt = $urandom_range(257, 511);
            default: nt = $urandom_range(3, 255);
          endcase
        end
      endcase
      write_num_targets(nt);
      if (phase == 2) begin
        // fill the map past full while the receiver holds off for a long stretch
        hold_requests <= hold_requests + 1;
        bucket_phase(MaxSources + 4, 1'b1);
      end else begin
        sources = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                              : $urandom_range(0, 40);
        bucket_phase(sources, 1'b0);
      end
      phase++;
    end

    drain();
    repeat (16) @(posedge clk);

    $display("run covered %0d requests in %0d phases, %0d results, %0d register writes",
             requests_taken, phase, results_seen, cfg_writes);
    $display("status mix: ok %0d, bad target %0d, full %0d, bad index %0d, not built %0d",
             status_tally[ST_OK], status_tally[ST_TARGET], status_tally[ST_FULL],
             status_tally[ST_INDEX], status_tally[ST_NOT_BUILT]);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mic_pkg.sv
hw/rtl/mic_datapath.sv
hw/rtl/mic_ctrl.sv
hw/rtl/map_inversion_csr_builder.sv
tb/map_inversion_csr_builder_test.sv
